// ===== rtl/tps_pkg.sv =====
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types, widths and fixed-point constants of the tidal phase series.
// ----------------------------------------------------------------------------
`default_nettype none

package tps_pkg;

  // port widths
  localparam int FREQ_W    = 24;
  localparam int PHASE_W   = 32;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MASS_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASS_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFORM_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEFORM_B = 3'd3;

  // register reset values
  localparam logic [CFG_W-1:0] MASS_RESET   = 24'h010000;
  localparam logic [CFG_W-1:0] DEFORM_RESET = 24'h000000;

  // rational correction coefficients, Q16
  localparam logic signed [63:0] K_N1   = -64'sd1142161;
  localparam logic signed [63:0] K_N32  = 64'sd2088436;
  localparam logic signed [63:0] K_N2   = -64'sd1731068;
  localparam logic signed [63:0] K_N52  = 64'sd4086956;
  localparam logic signed [63:0] K_D1   = -64'sd1305739;
  localparam logic signed [63:0] K_D32  = 64'sd2365129;
  localparam logic signed [63:0] K_ONE48 = 64'sd281474976710656;

  // prefactor scale 7.3125 in Q4
  localparam logic [7:0] K_PREF = 8'd117;

  // clamp for prefactor chain, 2^62
  localparam logic [63:0] CAP62 = 64'h4000_0000_0000_0000;

  // saturated phase codes
  localparam logic [PHASE_W-1:0] PHASE_MAX = 32'h7FFF_FFFF;
  localparam logic [PHASE_W-1:0] PHASE_MIN = 32'h8000_0000;

  // pipeline depths and widths
  localparam int ROOT_STEPS = 20;   // cube root result bits
  localparam int NUM_W      = 32;   // magnitude of truncated num and den
  localparam int DIV_W      = 56;   // quotient bits of the ratio divider

  // queue entry between front and back
  typedef struct packed {
    logic              valid;
    logic [FREQ_W-1:0] f;
  } head_t;

  // prefactor status toward the back part
  typedef struct packed {
    logic        busy;
    logic        sat;
    logic [62:0] value;
  } pref_t;

  // cube root stage payload
  typedef struct packed {
    logic [FREQ_W-1:0] f;
    logic [19:0]       c;
    logic [39:0]       c2;
    logic [59:0]       c3;
  } root_t;

  // flags carried alongside the ratio
  typedef struct packed {
    logic [30:0] x25;
    logic        qneg;
    logic        den_zero;
    logic        num_zero;
    logic        num_pos;
  } side_t;

  // divider stage payload
  typedef struct packed {
    logic [DIV_W-1:0] dq;
    logic [NUM_W-1:0] rem;
    logic [NUM_W-1:0] ad;
    side_t            side;
  } div_t;

endpackage

`default_nettype wire

// ===== rtl/tps_ifs.sv =====
// ----------------------------------------------------------------------------
// tps_ifs
// Valid/ready channels for frequency samples and phase results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tps_freq_if import tps_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] freq;

  modport source (output valid, output freq, input ready);
  modport sink (input valid, input freq, output ready);
endinterface

interface tps_phase_if import tps_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [PHASE_W-1:0] phase;
  logic                      overflow;

  modport source (output valid, output phase, output overflow, input ready);
  modport sink (input valid, input phase, input overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/tps_pref.sv =====
// ----------------------------------------------------------------------------
// tps_pref
// Configuration registers and the sequencer that derives the prefactor P
// from masses and deformabilities with one shared divider and multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_pref import tps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output pref_t                pref
);

  // sequencer steps
  localparam logic [4:0] OP_XA   = 5'd0;
  localparam logic [4:0] OP_XB   = 5'd1;
  localparam logic [4:0] OP_R    = 5'd2;
  localparam logic [4:0] OP_Q    = 5'd3;
  localparam logic [4:0] OP_A1   = 5'd4;
  localparam logic [4:0] OP_A2   = 5'd5;
  localparam logic [4:0] OP_A3   = 5'd6;
  localparam logic [4:0] OP_A4   = 5'd7;
  localparam logic [4:0] OP_A5   = 5'd8;
  localparam logic [4:0] OP_B1   = 5'd9;
  localparam logic [4:0] OP_B2   = 5'd10;
  localparam logic [4:0] OP_B3   = 5'd11;
  localparam logic [4:0] OP_B4   = 5'd12;
  localparam logic [4:0] OP_B5   = 5'd13;
  localparam logic [4:0] OP_SUM  = 5'd14;
  localparam logic [4:0] OP_PREF = 5'd15;

  // product shift codes
  localparam logic [1:0] SH4  = 2'd0;
  localparam logic [1:0] SH8  = 2'd1;
  localparam logic [1:0] SH32 = 2'd2;

  localparam int         PDIV_W   = 56;
  localparam logic [5:0] DIV_LAST = 6'(PDIV_W - 1);
  localparam logic [5:0] MUL_FIN  = 6'd4;

  logic [CFG_W-1:0] mass_a, mass_b, deform_a, deform_b;

  logic [4:0]   op;
  logic [5:0]   cnt;
  logic         ld;
  logic         busy;
  logic         sat;
  logic [62:0]  value;
  logic [55:0]  xa, xb, rr, qq;
  logic [63:0]  t, ta;
  logic [127:0] acc;
  logic [55:0]  dq;
  logic [24:0]  rem;

  logic             swap;
  logic [CFG_W-1:0] m1, m2, l1, l2;
  logic [24:0]      mt;
  logic [CFG_W-1:0] dm;
  logic [24:0]      dsor;
  logic [25:0]      rem_sh;
  logic             div_ge;
  logic [25:0]      rem_diff;
  logic [24:0]      rem_next;
  logic [55:0]      dq_next;
  logic [63:0]      ma, mb;
  logic [1:0]       msh;
  logic [31:0]      a_part, b_part;
  logic [63:0]      pp;
  logic [127:0]     pp_w;
  logic [127:0]     shifted;
  logic             msat;
  logic [63:0]      mres;
  logic [64:0]      s65;
  logic             ssat;
  logic [63:0]      sres;

  // heavier mass first, ties count as swapped
  assign swap = !(mass_a > mass_b);
  assign m1   = swap ? mass_b : mass_a;
  assign m2   = swap ? mass_a : mass_b;
  assign l1   = swap ? deform_b : deform_a;
  assign l2   = swap ? deform_a : deform_b;
  assign mt   = {1'b0, m1} + {1'b0, m2};

  // divider operands
  always_comb begin
    unique case (op[1:0])
      2'd0: begin dm = m1; dsor = mt; end
      2'd1: begin dm = m2; dsor = mt; end
      2'd2: begin dm = m1; dsor = {1'b0, m2}; end
      default: begin dm = m2; dsor = {1'b0, m1}; end
    endcase
  end

  // one restoring division bit per cycle
  assign rem_sh   = {rem, dq[55]};
  assign div_ge   = rem_sh >= {1'b0, dsor};
  assign rem_diff = rem_sh - {1'b0, dsor};
  assign rem_next = div_ge ? rem_diff[24:0] : rem_sh[24:0];
  assign dq_next  = {dq[54:0], div_ge};

  // multiplier operands
  always_comb begin
    ma  = t;
    mb  = t;
    msh = SH32;
    case (op)
      OP_A1:   begin ma = {8'd0, xa}; mb = {8'd0, xa}; end
      OP_A2:   begin mb = {8'd0, xa}; end
      OP_A3:   begin mb = {40'd0, l1}; msh = SH8; end
      OP_A4,
      OP_A5:   begin mb = {8'd0, rr}; end
      OP_B1:   begin ma = {8'd0, xb}; mb = {8'd0, xb}; end
      OP_B2:   begin mb = {8'd0, xb}; end
      OP_B3:   begin mb = {40'd0, l2}; msh = SH8; end
      OP_B4,
      OP_B5:   begin mb = {8'd0, qq}; end
      OP_PREF: begin mb = {56'd0, K_PREF}; msh = SH4; end
      default: ;
    endcase
  end

  // one 32x32 partial product per cycle
  assign a_part = cnt[0] ? ma[63:32] : ma[31:0];
  assign b_part = cnt[1] ? mb[63:32] : mb[31:0];
  assign pp     = a_part * b_part;

  always_comb begin
    unique case (cnt[1:0])
      2'd0:    pp_w = {64'd0, pp};
      2'd3:    pp_w = {pp, 64'd0};
      default: pp_w = {32'd0, pp, 32'd0};
    endcase
  end

  // scale and clamp the finished product
  always_comb begin
    unique case (msh)
      SH4:     shifted = acc >> 4;
      SH8:     shifted = acc >> 8;
      default: shifted = acc >> 32;
    endcase
  end

  assign msat = (|shifted[127:64]) || (shifted[63:0] > CAP62);
  assign mres = msat ? CAP62 : shifted[63:0];

  // sum of the two side terms
  assign s65  = {1'b0, ta} + {1'b0, t};
  assign ssat = s65 > {1'b0, CAP62};
  assign sres = ssat ? CAP62 : s65[63:0];

  // registers and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      mass_a   <= MASS_RESET;
      mass_b   <= MASS_RESET;
      deform_a <= DEFORM_RESET;
      deform_b <= DEFORM_RESET;
      busy     <= 1'b1;
      op       <= OP_XA;
      ld       <= 1'b1;
      sat      <= 1'b0;
      cnt      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MASS_A:   mass_a   <= cfg_data;
        REG_MASS_B:   mass_b   <= cfg_data;
        REG_DEFORM_A: deform_a <= cfg_data;
        REG_DEFORM_B: deform_b <= cfg_data;
        default: ;
      endcase
      busy <= 1'b1;
      op   <= OP_XA;
      ld   <= 1'b1;
      sat  <= 1'b0;
    end else if (busy) begin
      if (ld) begin
        cnt <= '0;
        acc <= '0;
        dq  <= {dm, 32'd0};
        rem <= '0;
        if (op == OP_XA && m2 == '0) begin
          sat   <= 1'b1;
          value <= '0;
          busy  <= 1'b0;
        end else if (op == OP_SUM) begin
          t   <= sres;
          sat <= sat | ssat;
          op  <= op + 5'd1;
        end else begin
          ld <= 1'b0;
        end
      end else if (op <= OP_Q) begin
        dq  <= dq_next;
        rem <= rem_next;
        cnt <= cnt + 6'd1;
        if (cnt == DIV_LAST) begin
          unique case (op[1:0])
            2'd0:    xa <= dq_next;
            2'd1:    xb <= dq_next;
            2'd2:    rr <= dq_next;
            default: qq <= dq_next;
          endcase
          op <= op + 5'd1;
          ld <= 1'b1;
        end
      end else begin
        if (cnt == MUL_FIN) begin
          t   <= mres;
          sat <= sat | msat;
          if (op == OP_A5) begin
            ta <= mres;
          end
          if (op == OP_PREF) begin
            value <= mres[62:0];
            busy  <= 1'b0;
          end
          op <= op + 5'd1;
          ld <= 1'b1;
        end else begin
          acc <= acc + pp_w;
          cnt <= cnt + 6'd1;
        end
      end
    end
  end

  assign pref.busy  = busy;
  assign pref.sat   = sat;
  assign pref.value = value;

endmodule

`default_nettype wire

// ===== rtl/tps_front.sv =====
// ----------------------------------------------------------------------------
// tps_front
// Accepts frequency samples and holds them in a two-entry queue for the
// back part.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_front import tps_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  tps_freq_if.sink        sample,
  input  logic            busy,
  input  logic            pop,
  output head_t           head
);

  logic [FREQ_W-1:0] mem [2];
  logic              wp, rp;
  logic [1:0]        count;
  logic              push;
  logic              take;

  // accept while there is room and the prefactor is settled
  assign sample.ready = (count != 2'd2) && !busy;
  assign push         = sample.valid && sample.ready;
  assign take         = pop && (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (take) begin
        rp <= !rp;
      end
      unique case ({push, take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= sample.freq;
    end
  end

  assign head.valid = count != 2'd0;
  assign head.f     = mem[rp];

endmodule

`default_nettype wire

// ===== rtl/tps_back.sv =====
// ----------------------------------------------------------------------------
// tps_back
// Per-sample pipeline: cube root, powers of x, rational correction, ratio
// divider, prefactor product, saturation and an output skid stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_back import tps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  head_t       head,
  output logic        pop,
  input  pref_t       pref,
  tps_phase_if.source result
);

  logic adv;

  // cube root stages
  root_t rs [0:ROOT_STEPS];
  logic  rv [0:ROOT_STEPS];

  // powers and products
  logic        m1_v, m2_v;
  logic [31:0] m1_xx, m1_x2;
  logic [30:0] m1_y, m1_x25, m2_x25;
  logic signed [63:0] pn1, pn2, pn3, pn4, pd1, pd2;

  // divider stages
  div_t ds [0:DIV_W];
  logic dv [0:DIV_W];

  // prefactor and magnitude stages
  logic        e1_v, e2_v, g1_v, g2_v;
  logic [62:0] e1_pl, e2_e;
  logic [61:0] e1_ph;
  logic [DIV_W-1:0] e1_q, e2_q;
  side_t       e1_side, e2_side, g1_side, g2_side;
  logic [59:0] g1_p00, g1_p01;
  logic [58:0] g1_p10, g1_p11;
  logic        g1_qnz, g2_qnz;
  logic [32:0] g2_mag;

  // output and skid
  logic               out_valid, sk_valid;
  logic [PHASE_W-1:0] out_phase, sk_phase;
  logic               out_ovf, sk_ovf;

  // pipeline moves while the skid slot is free
  assign adv = !sk_valid;
  assign pop = adv && head.valid;

  // load from the queue head
  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0] <= 1'b0;
    end else if (adv) begin
      rv[0] <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rs[0].f  <= head.f;
      rs[0].c  <= '0;
      rs[0].c2 <= '0;
      rs[0].c3 <= '0;
    end
  end

  // one cube root bit per stage, c^2 and c^3 kept incrementally
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam int B = ROOT_STEPS - 1 - k;
    logic [63:0] v, c2s, cs, t3;
    logic [39:0] c2n;
    logic        hit;

    assign v   = {5'd0, rs[k].f, 35'd0};
    assign c2s = {24'd0, rs[k].c2} << B;
    assign cs  = {44'd0, rs[k].c} << (2 * B);
    assign t3  = {4'd0, rs[k].c3} + c2s + (c2s << 1) + cs + (cs << 1)
               + (64'd1 << (3 * B));
    assign hit = t3 <= v;
    assign c2n = rs[k].c2 + ({20'd0, rs[k].c} << (B + 1)) + (40'd1 << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        rv[k+1] <= 1'b0;
      end else if (adv) begin
        rv[k+1] <= rv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rs[k+1].f  <= rs[k].f;
        rs[k+1].c  <= hit ? (rs[k].c | (20'd1 << B)) : rs[k].c;
        rs[k+1].c2 <= hit ? c2n : rs[k].c2;
        rs[k+1].c3 <= hit ? t3[59:0] : rs[k].c3;
      end
    end
  end

  // x, x^2 and x^2.5
  logic [31:0] xx;
  logic [30:0] yy;
  logic [63:0] xsq;
  logic [62:0] yx;

  assign xx  = rs[ROOT_STEPS].c2[39:8];
  assign yy  = {rs[ROOT_STEPS].f, 7'd0};
  assign xsq = xx * xx;
  assign yx  = yy * xx;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
      m2_v <= 1'b0;
    end else if (adv) begin
      m1_v <= rv[ROOT_STEPS];
      m2_v <= m1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_xx  <= xx;
      m1_y   <= yy;
      m1_x2  <= xsq[63:32];
      m1_x25 <= yx[62:32];
    end
  end

  // coefficient products
  always_ff @(posedge clk) begin
    if (adv) begin
      pn1    <= K_N1 * $signed({32'd0, m1_xx});
      pn2    <= K_N32 * $signed({33'd0, m1_y});
      pn3    <= K_N2 * $signed({32'd0, m1_x2});
      pn4    <= K_N52 * $signed({33'd0, m1_x25});
      pd1    <= K_D1 * $signed({32'd0, m1_xx});
      pd2    <= K_D32 * $signed({33'd0, m1_y});
      m2_x25 <= m1_x25;
    end
  end

  // num and den, truncated toward zero to Q24, as magnitude and sign
  logic signed [63:0] num, den;
  logic [63:0]        num_abs, den_abs;
  logic [NUM_W-1:0]   an, ad;

  assign num     = K_ONE48 + pn1 + pn2 + pn3 + pn4;
  assign den     = K_ONE48 + pd1 + pd2;
  assign num_abs = num[63] ? 64'(-num) : 64'(num);
  assign den_abs = den[63] ? 64'(-den) : 64'(den);
  assign an      = num_abs[55:24];
  assign ad      = den_abs[55:24];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= m2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds[0].dq            <= {an, 24'd0};
      ds[0].rem           <= '0;
      ds[0].ad            <= ad;
      ds[0].side.x25      <= m2_x25;
      ds[0].side.qneg     <= num[63] ^ den[63];
      ds[0].side.den_zero <= ad == '0;
      ds[0].side.num_zero <= an == '0;
      ds[0].side.num_pos  <= !num[63] && (an != '0);
    end
  end

  // ratio divider, one quotient bit per stage
  for (genvar i = 0; i < DIV_W; i++) begin : g_div
    logic [NUM_W:0]   rsh, diff;
    logic             ge;

    assign rsh  = {ds[i].rem, ds[i].dq[DIV_W-1]};
    assign ge   = rsh >= {1'b0, ds[i].ad};
    assign diff = rsh - {1'b0, ds[i].ad};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1] <= 1'b0;
      end else if (adv) begin
        dv[i+1] <= dv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ds[i+1].dq   <= {ds[i].dq[DIV_W-2:0], ge};
        ds[i+1].rem  <= ge ? diff[NUM_W-1:0] : rsh[NUM_W-1:0];
        ds[i+1].ad   <= ds[i].ad;
        ds[i+1].side <= ds[i].side;
      end
    end
  end

  // E = P * x^2.5 / 2^32, split across two partial products
  logic [62:0] pl;
  logic [61:0] ph;

  assign pl = pref.value[31:0] * ds[DIV_W].side.x25;
  assign ph = pref.value[62:32] * ds[DIV_W].side.x25;

  logic [94:0] eprod;
  logic [62:0] eraw;

  assign eprod = {32'd0, e1_pl} + {1'b0, e1_ph, 32'd0};
  assign eraw  = eprod[94:32];

  // magnitude = E * |ratio| / 2^44, clamped at 2^32
  logic [118:0] gtot;
  logic [74:0]  gshr;

  assign gtot = {59'd0, g1_p00} + {31'd0, g1_p01, 28'd0} + {28'd0, g1_p10, 32'd0}
              + {g1_p11, 60'd0};
  assign gshr = gtot[118:44];

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_v <= 1'b0;
      e2_v <= 1'b0;
      g1_v <= 1'b0;
      g2_v <= 1'b0;
    end else if (adv) begin
      e1_v <= dv[DIV_W];
      e2_v <= e1_v;
      g1_v <= e2_v;
      g2_v <= g1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_pl   <= pl;
      e1_ph   <= ph;
      e1_q    <= ds[DIV_W].dq;
      e1_side <= ds[DIV_W].side;

      e2_e    <= (eraw > CAP62[62:0]) ? CAP62[62:0] : eraw;
      e2_q    <= e1_q;
      e2_side <= e1_side;

      g1_p00  <= e2_e[31:0] * e2_q[27:0];
      g1_p01  <= e2_e[31:0] * e2_q[55:28];
      g1_p10  <= e2_e[62:32] * e2_q[27:0];
      g1_p11  <= e2_e[62:32] * e2_q[55:28];
      g1_qnz  <= |e2_q;
      g1_side <= e2_side;

      g2_mag  <= (|gshr[74:32]) ? 33'h1_0000_0000 : {1'b0, gshr[31:0]};
      g2_qnz  <= g1_qnz;
      g2_side <= g1_side;
    end
  end

  // sign, special cases and saturation
  logic               f_neg, f_ovf;
  logic [32:0]        f_mag;
  logic [PHASE_W-1:0] f_phase;
  logic               push;

  always_comb begin
    f_mag = '0;
    priority if (g2_side.den_zero) begin
      f_ovf = !g2_side.num_zero;
      f_neg = g2_side.num_pos;
    end else if (pref.sat) begin
      f_neg = g2_qnz && !g2_side.qneg;
      f_ovf = (g2_side.x25 != '0) && g2_qnz;
    end else begin
      f_neg = g2_qnz && !g2_side.qneg;
      f_mag = g2_mag;
      f_ovf = f_neg ? (g2_mag > 33'h0_8000_0000) : (g2_mag > 33'h0_7FFF_FFFF);
    end
  end

  assign f_phase = f_ovf ? (f_neg ? PHASE_MIN : PHASE_MAX)
                 : (f_neg ? (32'd0 - f_mag[31:0]) : f_mag[31:0]);
  assign push = adv && g2_v;

  // output register with skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (!out_valid || result.ready) begin
      if (sk_valid) begin
        out_valid <= 1'b1;
        out_phase <= sk_phase;
        out_ovf   <= sk_ovf;
        sk_valid  <= 1'b0;
      end else if (push) begin
        out_valid <= 1'b1;
        out_phase <= f_phase;
        out_ovf   <= f_ovf;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      sk_valid <= 1'b1;
      sk_phase <= f_phase;
      sk_ovf   <= f_ovf;
    end
  end

  assign result.valid    = out_valid;
  assign result.phase    = $signed(out_phase);
  assign result.overflow = out_ovf;

endmodule

`default_nettype wire

// ===== rtl/tidal_phase_series.sv =====
// ----------------------------------------------------------------------------
// tidal_phase_series
// Tidal phase correction for a stream of dimensionless frequency samples.
// ----------------------------------------------------------------------------
// Takes Q0.24 frequency samples and returns one Q20.12 phase per sample, in
// order, with a flag when the phase was saturated. With the 20-stage cube
// root pipeline and the 56-stage ratio divider, throughput is one sample per
// clock unless output back-pressure or the prefactor sequencer stalls it. The
// prefactor is derived from the mass and deformability registers by a
// sequencer with one bit-serial divider and one 32x32 multiplier, which runs
// after reset and after every register write; no sample is accepted while it
// runs. Write registers only while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module tidal_phase_series import tps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  tps_freq_if.sink             sample,
  tps_phase_if.source          result
);

  pref_t pref;
  head_t head;
  logic  pop;

  // prefactor from configuration
  tps_pref u_pref (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pref      (pref)
  );

  // sample intake and queue
  tps_front u_front (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .busy   (pref.busy),
    .pop    (pop),
    .head   (head)
  );

  // per-sample datapath
  tps_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .pref   (pref),
    .result (result)
  );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tidal phase series.
// ----------------------------------------------------------------------------
// Frequency samples go in over the sample channel. Each accepted transaction
// is run through a bit-exact predictor, and the expected phase and flag are
// queued. Results leaving the result channel are checked in order against
// that queue. Register settings change only while the pipeline is empty.
// The sender and the receiver idle at random in three phases.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import tps_pkg::*;

  localparam int  CYCLE_LIMIT = 600000;
  localparam int  DRAIN_WAIT  = 120;
  localparam int  RANDOM_ITEMS = 1400;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

  typedef struct packed {
    logic signed [PHASE_W-1:0] phase;
    logic                      ovf;
  } phase_exp_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  tps_freq_if  sample ();
  tps_phase_if result ();

  tidal_phase_series i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .result    (result)
  );

  // predictor copy of the registers
  logic [63:0] mass_a_q, mass_b_q, deform_a_q, deform_b_q;

  phase_exp_t phase_queue[$];
  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int cycles;

  // clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // floor(a*b / 2^sh) clamped to cap
  function automatic logic [63:0] scaled_mul(input logic [63:0] a, input logic [63:0] b,
                                             input int sh, input logic [63:0] cap,
                                             inout bit sat);
    logic [127:0] prod;
    prod = ({64'd0, a} * {64'd0, b}) >> sh;
    if (prod[127:64] != 0 || prod[63:0] > cap) begin
      sat = 1'b1;
      return cap;
    end
    return prod[63:0];
  endfunction

  // xs^3 * lambda * rr^2 for one body
  function automatic logic [63:0] body_term(input logic [63:0] xs, input logic [63:0] lam,
                                            input logic [63:0] rr, inout bit sat);
    logic [63:0] t;
    t = scaled_mul(xs, xs, 32, CAP62, sat);
    t = scaled_mul(t, xs, 32, CAP62, sat);
    t = scaled_mul(t, lam, 8, CAP62, sat);
    t = scaled_mul(t, rr, 32, CAP62, sat);
    return scaled_mul(t, rr, 32, CAP62, sat);
  endfunction

  // expected phase for one frequency sample
  function automatic phase_exp_t expected_phase(input logic [FREQ_W-1:0] f);
    logic [63:0] m1, m2, l1, l2, pref, mt, xa, xb, r, q, s, c, t, xx, y, x2, x25;
    logic [63:0] e, mag, ar;
    logic signed [63:0] num, den, ratio;
    bit psat, neg, ovf, big;
    phase_exp_t res;
    psat = 0; ovf = 0; big = 0; pref = 0; mag = 0; c = 0;
    if (mass_a_q > mass_b_q) begin
      m1 = mass_a_q; m2 = mass_b_q; l1 = deform_a_q; l2 = deform_b_q;
    end else begin
      m1 = mass_b_q; m2 = mass_a_q; l1 = deform_b_q; l2 = deform_a_q;
    end
    if (m2 == 0) begin
      psat = 1;
    end else begin
      mt = m1 + m2;
      xa = (m1 << 32) / mt;
      xb = (m2 << 32) / mt;
      r = (m1 << 32) / m2;
      q = (m2 << 32) / m1;
      s = body_term(xa, l1, r, psat);
      s = s + body_term(xb, l2, q, psat);
      if (s > CAP62) begin
        s = CAP62;
        psat = 1;
      end
      pref = scaled_mul(s, 64'(K_PREF), 4, CAP62, psat);
    end
    // integer cube root of f * 2^35
    for (int b = 19; b >= 0; b--) begin
      t = c | (64'd1 << b);
      if (t * t * t <= ({40'd0, f} << 35)) c = t;
    end
    xx = (c * c) >> 8;
    y = {40'd0, f} << 7;
    x2 = (xx * xx) >> 32;
    x25 = (y * xx) >> 32;
    num = K_ONE48 + K_N1 * $signed(xx) + K_N32 * $signed(y) + K_N2 * $signed(x2)
        + K_N52 * $signed(x25);
    den = K_ONE48 + K_D1 * $signed(xx) + K_D32 * $signed(y);
    num = num / 64'sd16777216;
    den = den / 64'sd16777216;
    if (den == 0) begin
      ovf = (num != 0);
      neg = (num > 0);
    end else begin
      ratio = (num * 64'sd16777216) / den;
      neg = (ratio > 0);
      if (psat) begin
        ovf = (x25 != 0 && ratio != 0);
      end else begin
        ar = (ratio < 0) ? 64'(-ratio) : 64'(ratio);
        e = scaled_mul(pref, x25, 32, CAP62, big);
        mag = scaled_mul(e, ar, 44, 64'h1_0000_0000, big);
        ovf = neg ? (mag > 64'h8000_0000) : (mag > 64'h7FFF_FFFF);
      end
    end
    if (ovf) res.phase = neg ? PHASE_MIN : PHASE_MAX;
    else if (neg) res.phase = -mag[31:0];
    else res.phase = mag[31:0];
    res.ovf = ovf;
    return res;
  endfunction

  // receiver: random backpressure and result checking
  always @(posedge clk) begin
    phase_exp_t want;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      result.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (result.valid && result.ready) begin
        if (phase_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transaction: phase %0d ovf %0b",
                     result.phase, result.overflow);
        end else begin
          want = phase_queue.pop_front();
          if (result.phase !== want.phase || result.overflow !== want.ovf) begin
            mismatches++;
            if (mismatches <= 10)
              $display("phase mismatch: expected %0d ovf %0b, got %0d ovf %0b",
                       want.phase, want.ovf, result.phase, result.overflow);
          end
        end
      end
    end
  end

  // one sample transaction, with random idle before it
  task automatic send_freq(input logic [FREQ_W-1:0] f);
    while ($urandom_range(99) < send_idle_pct) begin
      sample.valid <= 1'b0;
      @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.freq <= f;
    do @(posedge clk); while (!sample.ready);
    phase_queue.push_back(expected_phase(f));
  endtask

  // wait for the pipeline to empty
  task automatic drain();
    sample.valid <= 1'b0;
    while (phase_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // register write, pipeline idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MASS_A:   mass_a_q = val;
      REG_MASS_B:   mass_b_q = val;
      REG_DEFORM_A: deform_a_q = val;
      REG_DEFORM_B: deform_b_q = val;
      default: ;
    endcase
  endtask

  task automatic set_binary(input logic [CFG_W-1:0] ma, input logic [CFG_W-1:0] mb,
                            input logic [CFG_W-1:0] la, input logic [CFG_W-1:0] lb);
    write_reg(REG_MASS_A, ma);
    write_reg(REG_MASS_B, mb);
    write_reg(REG_DEFORM_A, la);
    write_reg(REG_DEFORM_B, lb);
  endtask

  // register defaults give zero deformability
  task automatic test_reset_defaults();
    send_freq(24'h000000);
    send_freq(24'hFFFFFF);
    send_freq(24'h001000);
  endtask

  // frequency extremes with a typical neutron star pair
  task automatic test_freq_extremes();
    set_binary(24'h016666, 24'h014000, 24'h019000, 24'h02BC00);
    send_freq(24'h000000);
    send_freq(24'h000001);
    send_freq(24'h000100);
    send_freq(24'h00A000);
    send_freq(24'h800000);
    send_freq(24'hFFFFFF);
  endtask

  // mass ordering, ties and unknown register index
  task automatic test_mass_order();
    set_binary(24'h014000, 24'h016666, 24'h02BC00, 24'h019000);
    send_freq(24'h004000);
    write_reg(REG_MASS_B, 24'h014000);
    send_freq(24'h004000);
    write_reg(REG_UNUSED, 24'h000001);
    send_freq(24'h004000);
  endtask

  // saturated prefactor, smaller mass zero and phase clamping
  task automatic test_saturation();
    set_binary(24'hFFFFFF, 24'h000001, 24'hFFFFFF, 24'hFFFFFF);
    send_freq(24'h000000);
    send_freq(24'h002000);
    send_freq(24'hFFFFFF);
    write_reg(REG_MASS_B, 24'h000000);
    send_freq(24'h000000);
    send_freq(24'h020000);
    set_binary(24'h000001, 24'hFFFFFF, 24'hFFFFFF, 24'h000000);
    send_freq(24'h040000);
    send_freq(24'h7FFFFF);
  endtask

  function automatic logic [FREQ_W-1:0] rand_freq();
    case ($urandom_range(3))
      0: return FREQ_W'($urandom_range(24'hFFFFFF));
      1: return FREQ_W'($urandom_range(24'h00FFFF));
      2: return FREQ_W'($urandom_range(24'h0FFFFF));
      default: return FREQ_W'($urandom_range(24'h000FFF));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_mass();
    case ($urandom_range(3))
      0: return CFG_W'($urandom_range(24'hFFFFFF, 24'h000001));
      default: return CFG_W'($urandom_range(24'h030000, 24'h00C000));
    endcase
  endfunction

  // random binaries and samples under one idle setting
  task automatic test_random(input int s_pct, input int r_pct, input int count);
    logic [CFG_W-1:0] ma;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        ma = rand_mass();
        set_binary(ma, ($urandom_range(3) == 0) ? ma : rand_mass(),
                   ($urandom_range(3) == 0) ? CFG_W'($urandom_range(24'hFFFFFF))
                                            : CFG_W'($urandom_range(24'h0FFFFF)),
                   CFG_W'($urandom_range(24'hFFFFFF)));
      end
      send_freq(rand_freq());
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_MASS_A;
    cfg_data = '0;
    sample.valid = 1'b0;
    sample.freq = '0;
    result.ready = 1'b0;
    cycles = 0;
    mismatches = 0;
    send_idle_pct = 15;
    recv_idle_pct = 82;
    mass_a_q = MASS_RESET;
    mass_b_q = MASS_RESET;
    deform_a_q = DEFORM_RESET;
    deform_b_q = DEFORM_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_freq_extremes();
    test_mass_order();
    test_saturation();
    test_random(15, 82, RANDOM_ITEMS / 3);
    test_random(82, 15, RANDOM_ITEMS / 3);
    test_random(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    drain();

    if (mismatches == 0 && phase_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/tps_pkg.sv
rtl/tps_ifs.sv
rtl/tps_pref.sv
rtl/tps_front.sv
rtl/tps_back.sv
rtl/tidal_phase_series.sv
sim/testbench.sv
